// File: hdl/fps_pkg.sv
// fps_pkg: shared types and constants for the fenwick prefix-sum table
// used by fps_ctrl, fps_datapath and fenwick_prefix_sum_table; no dependencies
package fps_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int PTR_W       = ADDR_W + 1;
	localparam int CFG_W       = 11;
	localparam int DATA_W      = 32;
	localparam int CMD_W       = 2;

	typedef enum logic [CMD_W-1:0] {
		OP_ADD    = 2'd0,
		OP_PREFIX = 2'd1,
		OP_RANGE  = 2'd2,
		OP_BAD    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_ADD_CHK,
		ST_ADD_WR,
		ST_Q_CHK,
		ST_Q_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic dispatch;
		logic add_rd;
		logic add_wr;
		logic q_rd;
		logic q_acc;
		logic q_second;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		op_t  op;
		logic req_err;
		logic add_live;
		logic q_live;
		logic second;
	} dp_stat_t;

endpackage

// File: hdl/fenwick_prefix_sum_table.sv
// fenwick_prefix_sum_table: top level of the binary indexed tree block
// depends on fps_pkg, fps_ctrl and fps_datapath
//
// channel   | signals                            | handshake
// ----------+------------------------------------+--------------------------------
// request   | cmd, index, lo_index, delta        | taken on start && !busy
// result    | total, error                       | valid for one cycle on done
// config    | cfg_wdata (table_size)             | written on cfg_we, any time
//
// after reset a clearing pass zeroes the 1024 nodes, one a cycle, with busy held high
// each node visit is a registered read
// an add touches the nodes on the i|(i+1) walk (at most 11)
// a prefix query visits one node per set bit of index+1 (at most 10)
// a range query walks both chains; a rejected request goes straight to the result
// results cannot be held off; done lasts one cycle and busy falls the cycle after
module fenwick_prefix_sum_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [fps_pkg::CMD_W-1:0]         cmd,
	input  logic [fps_pkg::ADDR_W-1:0]        index,
	input  logic [fps_pkg::ADDR_W-1:0]        lo_index,
	input  logic signed [fps_pkg::DATA_W-1:0] delta,
	output logic                              done,
	output logic signed [fps_pkg::DATA_W-1:0] total,
	output logic                              error,
	input  logic                              cfg_we,
	input  logic [fps_pkg::CFG_W-1:0]         cfg_wdata
);
	import fps_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// sequencer: clearing pass, walk steps, result strobe
	fps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dp_stat),
		.cmd    (dp_cmd),
		.busy   (busy),
		.done   (done)
	);

	// node store, pointer arithmetic and accumulation
	fps_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op_in     (cmd),
		.index     (index),
		.lo_index  (lo_index),
		.delta     (delta),
		.total     (total),
		.error     (error)
	);

endmodule

// File: hdl/fps_ctrl.sv
// fps_ctrl: sequencer for clearing, index walks and result timing
// depends on fps_pkg
module fps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fps_pkg::dp_stat_t stat,
	output fps_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import fps_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (stat.req_err) state_d = ST_DONE;
				else if (stat.op == OP_ADD) state_d = ST_ADD_CHK;
				else state_d = ST_Q_CHK;
			end
			ST_ADD_CHK: begin
				state_d = stat.add_live ? ST_ADD_WR : ST_DONE;
			end
			ST_ADD_WR: state_d = ST_ADD_CHK;
			ST_Q_CHK: begin
				if (stat.q_live) state_d = ST_Q_ACC;
				else if (stat.op == OP_RANGE && !stat.second) state_d = ST_Q_CHK;
				else state_d = ST_DONE;
			end
			ST_Q_ACC: state_d = ST_Q_CHK;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_DISPATCH: cmd.dispatch = 1'b1;
			ST_ADD_CHK:  cmd.add_rd = stat.add_live;
			ST_ADD_WR:   cmd.add_wr = 1'b1;
			ST_Q_CHK: begin
				cmd.q_rd     = stat.q_live;
				cmd.q_second = !stat.q_live && stat.op == OP_RANGE && !stat.second;
			end
			ST_Q_ACC: cmd.q_acc = 1'b1;
			ST_DONE:  done = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

endmodule

// File: hdl/fps_datapath.sv
// fps_datapath: node store, walk pointer, accumulator and size register
// depends on fps_pkg
module fps_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fps_pkg::dp_cmd_t           cmd,
	output fps_pkg::dp_stat_t          stat,
	input  logic                       cfg_we,
	input  logic [fps_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic [fps_pkg::CMD_W-1:0]  op_in,
	input  logic [fps_pkg::ADDR_W-1:0] index,
	input  logic [fps_pkg::ADDR_W-1:0] lo_index,
	input  logic signed [fps_pkg::DATA_W-1:0] delta,
	output logic signed [fps_pkg::DATA_W-1:0] total,
	output logic                       error
);
	import fps_pkg::*;

	logic [DATA_W-1:0] mem [MAX_ENTRIES];
	logic [DATA_W-1:0] rdata_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic [CFG_W-1:0]  size_cfg_q;
	logic [PTR_W-1:0]  live_size;
	logic [PTR_W-1:0]  ptr_q;
	logic [DATA_W-1:0] acc_q;
	logic              second_q;
	logic              err_q;
	op_t               op_q;
	logic [ADDR_W-1:0] hi_q, lo_q;
	logic [DATA_W-1:0] delta_q;
	logic [PTR_W-1:0]  ptr_dec;
	logic [PTR_W-1:0]  hi_ext;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;

	// sizes above the store saturate
	assign live_size = (size_cfg_q > CFG_W'(MAX_ENTRIES)) ? PTR_W'(MAX_ENTRIES)
	                                                      : PTR_W'(size_cfg_q);
	assign ptr_dec = ptr_q - PTR_W'(1);
	assign hi_ext  = {1'b0, hi_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_cfg_q <= CFG_W'(MAX_ENTRIES);
			clr_cnt_q  <= '0;
		end else begin
			if (cfg_we) size_cfg_q <= cfg_wdata;
			if (cmd.clr_step) clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
		end
	end

	always_comb begin
		stat.clr_last = &clr_cnt_q;
		stat.op       = op_q;
		stat.add_live = ptr_q < live_size;
		stat.q_live   = ptr_q != '0;
		stat.second   = second_q;
		case (op_q)
			OP_ADD:    stat.req_err = 1'b0;
			OP_PREFIX: stat.req_err = hi_ext >= live_size;
			OP_RANGE:  stat.req_err = (hi_ext >= live_size) || (lo_q > hi_q);
			default:   stat.req_err = 1'b1;
		endcase
	end

	// request fields and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(op_in);
			hi_q    <= index;
			lo_q    <= lo_index;
			delta_q <= delta;
		end
		if (cmd.dispatch) begin
			ptr_q    <= (op_q == OP_ADD) ? hi_ext : hi_ext + PTR_W'(1);
			acc_q    <= '0;
			second_q <= 1'b0;
			err_q    <= stat.req_err;
		end
		if (cmd.add_wr) ptr_q <= ptr_q | (ptr_q + PTR_W'(1));
		if (cmd.q_acc) begin
			ptr_q <= ptr_q & ptr_dec;
			acc_q <= second_q ? acc_q - rdata_q : acc_q + rdata_q;
		end
		if (cmd.q_second) begin
			ptr_q    <= {1'b0, lo_q};
			second_q <= 1'b1;
		end
	end

	assign rd_addr = cmd.q_rd ? ptr_dec[ADDR_W-1:0] : ptr_q[ADDR_W-1:0];
	assign wr_en   = cmd.clr_step || cmd.add_wr;
	assign wr_addr = cmd.clr_step ? clr_cnt_q : ptr_q[ADDR_W-1:0];
	assign wr_data = cmd.clr_step ? '0 : rdata_q + delta_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.add_rd || cmd.q_rd) rdata_q <= mem[rd_addr];
	end

	assign total = acc_q;
	assign error = err_q;

endmodule

// File: hdl/fps_checker.sv
// fps_checker: port-level assertions for fenwick_prefix_sum_table
// bound to the top level below; no package dependency
module fps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] total,
	input logic        error
);

	// a result lasts exactly one cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for more than one cycle");

	// an accepted request makes the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request taken but not busy");

	// results only appear while a request is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");

	// rejected requests report a zero sum
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error) |-> total == 32'd0) else $error("error with nonzero total");

	// block returns to idle straight after a result
	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result");

endmodule

bind fenwick_prefix_sum_table fps_checker u_fps_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.total  (total),
	.error  (error)
);

// File: sim/fps_sum_checker.sv
`timescale 1ns / 1ps
// fps_sum_checker: watches the request, result and config channels of the prefix-sum table
// keeps its own node store and size register; depends on fps_pkg only
module fps_sum_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [fps_pkg::CMD_W-1:0]         cmd,
	input  logic [fps_pkg::ADDR_W-1:0]        index,
	input  logic [fps_pkg::ADDR_W-1:0]        lo_index,
	input  logic signed [fps_pkg::DATA_W-1:0] delta,
	input  logic                              done,
	input  logic signed [fps_pkg::DATA_W-1:0] total,
	input  logic                              error,
	input  logic                              cfg_we,
	input  logic [fps_pkg::CFG_W-1:0]         cfg_wdata,
	output int                                fail_count,
	output int                                pending,
	output int                                checked
);
	import fps_pkg::*;

	typedef struct {
		int unsigned              seq;
		op_t                      op;
		logic [ADDR_W-1:0]        hi;
		logic signed [DATA_W-1:0] total;
		logic                     error;
	} due_sum_t;

	logic [DATA_W-1:0] nodes [MAX_ENTRIES];
	logic [CFG_W-1:0]  size_reg;
	due_sum_t          due_sums [$];
	due_sum_t          oldest;
	int unsigned       seq_no;

	initial begin
		fail_count = 0;
		pending    = 0;
		checked    = 0;
	end

	function automatic int unsigned live_entries();
		return (size_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(size_reg);
	endfunction

	// sum of entries 0..count-1, clearing the lowest set bit each step
	function automatic logic [DATA_W-1:0] chain_sum(input int unsigned count);
		logic [DATA_W-1:0] acc;
		int unsigned       p;
		acc = '0;
		p   = count;
		while (p != 0) begin
			acc += nodes[p - 1];
			p   &= p - 1;
		end
		return acc;
	endfunction

	// applies one request to the node copy and returns the result it should give
	function automatic due_sum_t predict_sum(input op_t op, input logic [ADDR_W-1:0] hi,
			input logic [ADDR_W-1:0] lo, input logic [DATA_W-1:0] amt);
		due_sum_t    r;
		int unsigned n;
		int unsigned i;
		int unsigned hi_i;
		int unsigned lo_i;
		n       = live_entries();
		hi_i    = hi;
		lo_i    = lo;
		r.seq   = seq_no;
		r.op    = op;
		r.hi    = hi;
		r.total = '0;
		r.error = 1'b0;
		case (op)
			OP_ADD: begin
				i = hi_i;
				while (i < n) begin
					nodes[i] += amt;
					i = i | (i + 1);
				end
			end
			OP_PREFIX: begin
				if (hi_i >= n)
					r.error = 1'b1;
				else
					r.total = chain_sum(hi_i + 1);
			end
			OP_RANGE: begin
				if (hi_i >= n || lo_i > hi_i)
					r.error = 1'b1;
				else
					r.total = chain_sum(hi_i + 1) - chain_sum(lo_i);
			end
			default: r.error = 1'b1;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_ENTRIES; k++)
				nodes[k] = '0;
			size_reg = CFG_W'(MAX_ENTRIES);
			due_sums.delete();
			seq_no  = 0;
			pending = 0;
		end else begin
			// result first: it belongs to a request taken at an earlier edge
			if (done) begin
				if (due_sums.size() == 0) begin
					report_mismatch($sformatf("result total=%0d error=%0b with nothing due",
						total, error));
				end else begin
					oldest = due_sums.pop_front();
					if (total !== oldest.total)
						report_mismatch($sformatf("request %0d %s index %0d: total %0d, want %0d",
							oldest.seq, oldest.op.name(), oldest.hi, total, oldest.total));
					if (error !== oldest.error)
						report_mismatch($sformatf("request %0d %s index %0d: error %b, want %b",
							oldest.seq, oldest.op.name(), oldest.hi, error, oldest.error));
					checked++;
				end
			end
			if (cfg_we)
				size_reg = cfg_wdata;
			if (start && !busy) begin
				due_sums.insert(due_sums.size(), predict_sum(op_t'(cmd), index, lo_index, delta));
				seq_no++;
			end
			pending = due_sums.size();
		end
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for fenwick_prefix_sum_table
// depends on fps_pkg, the block under test and fps_sum_checker
module tb;
	import fps_pkg::*;

	// no acceptance on either channel for this long means the block is stuck;
	// the clearing pass after reset falls inside this limit too
	localparam int IDLE_LIMIT   = 6000;
	// the slowest request is a range sum
	localparam int DRAIN_CYCLES = 64;
	localparam int PHASE_ITEMS  = 150;
	localparam int NUM_PHASES   = 10;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [CMD_W-1:0]         cmd;
	logic [ADDR_W-1:0]        index;
	logic [ADDR_W-1:0]        lo_index;
	logic signed [DATA_W-1:0] delta;
	logic                     done;
	logic signed [DATA_W-1:0] total;
	logic                     error;
	logic                     cfg_we;
	logic [CFG_W-1:0]         cfg_wdata;

	int fail_count;
	int pending;
	int checked;
	int sent      = 0;
	int idle_run  = 0;
	int settings  = 0;
	int cur_size  = MAX_ENTRIES;
	bit steady    = 1'b0;   // set for a stretch with no sender gaps

	// table sizes per random phase: extremes, saturation above the store, size zero,
	// shrinking and growing while the nodes keep earlier adds
	int phase_sizes [NUM_PHASES] = '{1024, 1, 2, 37, 2047, 300, 1023, 0, 512, 1536};

	fenwick_prefix_sum_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.index     (index),
		.lo_index  (lo_index),
		.delta     (delta),
		.done      (done),
		.total     (total),
		.error     (error),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	fps_sum_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.index      (index),
		.lo_index   (lo_index),
		.delta      (delta),
		.done       (done),
		.total      (total),
		.error      (error),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: counts edges at which neither a request nor a result is taken
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_run <= 0;
		end else begin
			idle_run <= idle_run + 1;
			if (idle_run >= IDLE_LIMIT) begin
				$display("timeout after %0d quiet cycles, %0d results still due", idle_run, pending);
				$display("** fenwick_prefix_sum_table: FAILED **");
				$finish;
			end
		end
	end

	// one request: start low while the block is busy and for random gaps once it is idle,
	// then start held until busy is low at an edge; with no gap the request follows at once
	task automatic send_req(input op_t op, input int hi, input int lo, input logic [31:0] amt);
		@(negedge clk);
		while (busy || (!steady && $urandom_range(0, 99) < 11)) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start    <= 1'b1;
		cmd      <= op;
		index    <= ADDR_W'(hi);
		lo_index <= ADDR_W'(lo);
		delta    <= amt;
		do
			@(posedge clk);
		while (busy);
		sent++;
	endtask

	// stop the sender and wait for every due result to come back
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// size register write, only with the block idle and nothing due
	task automatic write_size(input int s);
		drain_results();
		while (busy)
			@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= CFG_W'(s);
		@(negedge clk);
		cfg_we   <= 1'b0;
		cur_size  = s;
		settings++;
	endtask

	// mostly well-formed requests inside the live size, some noise outside it
	task automatic random_req();
		int          n;
		int          roll;
		int          hi;
		int          lo;
		op_t         op;
		logic [31:0] amt;
		n    = (cur_size > MAX_ENTRIES) ? MAX_ENTRIES : cur_size;
		roll = $urandom_range(0, 99);
		case ($urandom_range(0, 7))
			0:       amt = 32'h7fff_ffff;
			1:       amt = 32'h8000_0000;
			2, 3:    amt = $urandom_range(0, 200) - 32'd100;
			default: amt = $urandom();
		endcase
		if (n == 0 || roll < 10) begin
			// noise: unused command, index past the size, reversed range
			op = op_t'($urandom_range(0, 3));
			hi = $urandom_range(0, MAX_ENTRIES - 1);
			lo = $urandom_range(0, MAX_ENTRIES - 1);
		end else begin
			case ($urandom_range(0, 7))
				0:       hi = 0;
				1:       hi = n - 1;
				default: hi = $urandom_range(0, n - 1);
			endcase
			if (roll < 50)
				op = OP_ADD;
			else if (roll < 75)
				op = OP_PREFIX;
			else
				op = OP_RANGE;
			// lo only matters for a range; elsewhere it is left to roam
			lo = (op == OP_RANGE) ? $urandom_range(0, hi) : $urandom_range(0, MAX_ENTRIES - 1);
		end
		send_req(op, hi, lo, amt);
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = OP_ADD;
		index     = '0;
		lo_index  = '0;
		delta     = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part: full size first, waits out the clearing pass
		write_size(MAX_ENTRIES);
		send_req(OP_ADD, 0, 0, 32'h7fff_ffff);
		send_req(OP_ADD, 1023, 0, 32'h8000_0000);
		send_req(OP_ADD, 512, 1023, 32'hffff_ffff);
		send_req(OP_ADD, 1023, 0, 32'h0000_0001);        // adds one to the last node only, no wrap
		send_req(OP_PREFIX, 0, 0, 32'h0);
		send_req(OP_PREFIX, 1023, 0, 32'hffff_ffff);
		send_req(OP_PREFIX, 511, 0, 32'h0);
		send_req(OP_RANGE, 1023, 0, 32'h0);
		send_req(OP_RANGE, 1023, 1023, 32'h0);
		send_req(OP_RANGE, 0, 1023, 32'h0);              // reversed range
		send_req(OP_RANGE, 4, 5, 32'h0);                 // reversed by one
		send_req(OP_BAD, 1023, 1023, 32'hffff_ffff);     // unused command

		// shrink: an add past the size is dropped, a query past it errors
		write_size(10);
		send_req(OP_ADD, 500, 0, 32'h1234_5678);
		send_req(OP_ADD, 9, 0, 32'h0000_0005);
		send_req(OP_PREFIX, 9, 0, 32'h0);
		send_req(OP_PREFIX, 10, 0, 32'h0);
		send_req(OP_RANGE, 9, 3, 32'h0);

		// size zero: nothing is in range
		write_size(0);
		send_req(OP_ADD, 0, 0, 32'h0000_0001);
		send_req(OP_PREFIX, 0, 0, 32'h0);
		send_req(OP_RANGE, 0, 0, 32'h0);

		// all size bits set, saturates to the store depth; nodes kept from before
		write_size(2047);
		send_req(OP_PREFIX, 1023, 0, 32'h0);
		send_req(OP_RANGE, 1023, 9, 32'h0);

		write_size(16);
		send_req(OP_ADD, 15, 0, 32'h5555_5555);
		send_req(OP_PREFIX, 15, 0, 32'h0);

		// random phases, one size setting each
		phase_sizes[8] = $urandom_range(1, MAX_ENTRIES);
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_size(phase_sizes[ph]);
			steady = (ph == 4 || ph == 5);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// now and then hold the sender off until everything is back
				if ($urandom_range(0, 99) == 0)
					drain_results();
				random_req();
			end
		end
		steady = 1'b0;

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d requests over %0d size settings, %0d results compared",
			sent, settings, checked);
		if (fail_count == 0 && pending == 0)
			$display("** fenwick_prefix_sum_table: PASSED **");
		else
			$display("** fenwick_prefix_sum_table: FAILED **");
		$finish;
	end

endmodule

// File: fenwick_prefix_sum_table.f
hdl/fps_pkg.sv
hdl/fps_ctrl.sv
hdl/fps_datapath.sv
hdl/fenwick_prefix_sum_table.sv
hdl/fps_checker.sv
sim/fps_sum_checker.sv
sim/tb.sv
